// ----- rtl/sma_pkg.sv -----
package sma_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);
  localparam int ACT_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_OUT_W = 7;

  localparam logic [ACT_W-1:0] ACT_NOP  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADD  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SUB  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_MUL  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_OP,
    S_DIV,
    S_FIX,
    S_WB,
    S_DONE
  } sma_state_t;

  typedef struct packed {
    logic             push;
    logic             rd;
    logic             latch_a;
    logic             alu_go;
    logic             div_init;
    logic             div_step;
    logic             div_fix;
    logic             wb;
    logic [ACT_W-1:0] op;
  } sma_cmd_t;

  typedef struct packed {
    logic full;
    logic short_stk;
    logic top_zero;
    logic div_last;
  } sma_stat_t;

endpackage

// ----- rtl/sma_ram.sv -----
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sma_ctrl.sv -----
module sma_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [sma_pkg::ACT_W-1:0]       in_action,
  input  sma_pkg::sma_stat_t              stat,
  output sma_pkg::sma_cmd_t               cmd,
  output logic                            busy,
  output logic                            out_strobe,
  output logic [sma_pkg::STATUS_W-1:0]    out_status
);

  import sma_pkg::*;

  sma_state_t          state_r, state_nxt;
  logic [ACT_W-1:0]    act_r, act_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      act_r    <= ACT_NOP;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      act_r    <= act_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    status_nxt   = status_r;
    cmd          = '0;
    cmd.op       = act_r;
    busy         = 1'b1;
    out_strobe   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          act_nxt    = in_action;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          unique case (in_action)
            ACT_PUSH: begin
              if (stat.full) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            ACT_ADD, ACT_SUB, ACT_MUL: begin
              if (stat.short_stk) begin
                status_nxt = ST_SHORT;
              end else begin
                cmd.rd    = 1'b1;
                state_nxt = S_RD;
              end
            end
            ACT_DIV: begin
              priority if (stat.short_stk) begin
                status_nxt = ST_SHORT;
              end else if (stat.top_zero) begin
                status_nxt = ST_DIV0;
              end else begin
                cmd.rd    = 1'b1;
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        cmd.latch_a = 1'b1;
        state_nxt   = S_OP;
      end
      S_OP: begin
        if (act_r == ACT_DIV) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.alu_go = 1'b1;
          state_nxt  = S_WB;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_WB;
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_strobe = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_status = status_r;

endmodule

// ----- rtl/sma_dp.sv -----
module sma_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sma_pkg::sma_cmd_t                  cmd,
  input  logic signed [sma_pkg::DATA_W-1:0]  in_push_value,
  output sma_pkg::sma_stat_t                 stat,
  output logic signed [sma_pkg::DATA_W-1:0]  out_top_value,
  output logic [sma_pkg::DEPTH_OUT_W-1:0]    out_stack_depth
);

  import sma_pkg::*;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0]    top_r, top_nxt;
  logic [DATA_W-1:0]    opa_r, opa_nxt;
  logic [DATA_W-1:0]    res_r, res_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W-1:0]    mb_r, mb_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic [CNT_W-1:0]     below_cnt;
  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;
  logic [DATA_W-1:0]    ram_rdata;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      trial;

  assign below_cnt = count_r - CNT_W'(2);

  sma_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (below_cnt[PTR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    opa_r     <= opa_nxt;
    res_r     <= res_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    mb_r      <= mb_nxt;
    neg_r     <= neg_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign trial  = rem_sh - {1'b0, mb_r};

  always_comb begin
    count_nxt   = count_r;
    top_nxt     = top_r;
    opa_nxt     = opa_r;
    res_nxt     = res_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    mb_nxt      = mb_r;
    neg_nxt     = neg_r;
    div_cnt_nxt = div_cnt_r;
    ram_we      = 1'b0;
    ram_waddr   = below_cnt[PTR_W-1:0];
    ram_wdata   = res_r;

    if (cmd.push) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[PTR_W-1:0];
      ram_wdata = in_push_value;
      top_nxt   = in_push_value;
      count_nxt = count_r + CNT_W'(1);
    end

    if (cmd.latch_a) begin
      opa_nxt = ram_rdata;
    end

    if (cmd.alu_go) begin
      unique case (cmd.op)
        ACT_ADD: res_nxt = opa_r + top_r;
        ACT_SUB: res_nxt = opa_r - top_r;
        default: res_nxt = DATA_W'(opa_r * top_r);
      endcase
    end

    if (cmd.div_init) begin
      quo_nxt     = opa_r[DATA_W-1] ? (DATA_W'(0) - opa_r) : opa_r;
      mb_nxt      = top_r[DATA_W-1] ? (DATA_W'(0) - top_r) : top_r;
      neg_nxt     = opa_r[DATA_W-1] ^ top_r[DATA_W-1];
      rem_nxt     = '0;
      div_cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      if (!trial[DATA_W]) begin
        rem_nxt = trial[DATA_W-1:0];
      end else begin
        rem_nxt = rem_sh[DATA_W-1:0];
      end
      quo_nxt     = {quo_r[DATA_W-2:0], ~trial[DATA_W]};
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
    end

    if (cmd.div_fix) begin
      res_nxt = neg_r ? (DATA_W'(0) - quo_r) : quo_r;
    end

    if (cmd.wb) begin
      ram_we    = 1'b1;
      ram_waddr = below_cnt[PTR_W-1:0];
      ram_wdata = res_r;
      top_nxt   = res_r;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign stat.full      = (count_r >= CNT_W'(STACK_DEPTH));
  assign stat.short_stk = (count_r < CNT_W'(2));
  assign stat.top_zero  = (top_r == '0);
  assign stat.div_last  = (div_cnt_r == DIV_CNT_W'(DATA_W - 1));

  assign out_top_value   = (count_r != '0) ? top_r : '0;
  assign out_stack_depth = DEPTH_OUT_W'(count_r);

endmodule

// ----- rtl/stack_machine_alu.sv -----
// Channel   Handshake             Ports
// input     start high, busy low  in_action, in_push_value
// result    out_strobe, 1 cycle   out_status, out_top_value, out_stack_depth
//
// nop, unused codes, push, every error: result straight after accept; busy until it shows.
// add, sub, mul: read the second entry, compute, write back, then show the result.
// div: read, set up, run the radix-2 divider loop, fix the sign, write back, then show it.
// Reset empties the stack; entries are not cleared and are only read below the count.
// The receiver cannot stall: each result shows for one cycle only.
module stack_machine_alu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [sma_pkg::ACT_W-1:0]           in_action,
  input  logic signed [sma_pkg::DATA_W-1:0]   in_push_value,
  output logic                                out_strobe,
  output logic [sma_pkg::STATUS_W-1:0]        out_status,
  output logic signed [sma_pkg::DATA_W-1:0]   out_top_value,
  output logic [sma_pkg::DEPTH_OUT_W-1:0]     out_stack_depth
);

  import sma_pkg::*;

  sma_cmd_t  cmd;
  sma_stat_t stat;

  sma_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_action  (in_action),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_status (out_status)
  );

  sma_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_push_value   (in_push_value),
    .stat            (stat),
    .out_top_value   (out_top_value),
    .out_stack_depth (out_stack_depth)
  );

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FULL) |-> out_stack_depth == DEPTH_OUT_W'(STACK_DEPTH))
    else $error("stack full reported below full depth");

  a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == ACT_PUSH && out_stack_depth == DEPTH_OUT_W'(0))
      |=> out_stack_depth == DEPTH_OUT_W'(1))
    else $error("push onto empty stack did not raise depth");
`endif

endmodule

// ----- tb/sv/tb_stack_machine_alu.sv -----
`timescale 1ns / 100ps

module tb_stack_machine_alu;
  import sma_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;
  localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;
  localparam int RANDOM_ITEMS = 920;
  localparam int QUIET_TAIL = 150;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] value;
    int                gap;
    bit                drain;
  } alu_item_t;

  typedef struct {
    logic [STATUS_W-1:0]    status;
    logic [DATA_W-1:0]      top;
    logic [DEPTH_OUT_W-1:0] depth;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ACT_W-1:0] in_action = ACT_NOP;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic signed [DATA_W-1:0] out_top_value;
  logic [DEPTH_OUT_W-1:0] out_stack_depth;

  alu_item_t   pending_items[$];
  alu_result_t expected_results[$];
  logic [DATA_W-1:0] model_stack [STACK_DEPTH];
  int model_count = 0;
  int hold_cnt = 0;
  int fail_count = 0;
  int cycle_cnt = 0;
  bit stim_done = 1'b0;
  bit idle_on = 1'b1;

  stack_machine_alu DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_push_value   (in_push_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_top_value   (out_top_value),
    .out_stack_depth (out_stack_depth)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic alu_result_t apply_action(input logic [ACT_W-1:0] act,
                                               input logic [DATA_W-1:0] val);
    alu_result_t res;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    bit done;
    res.status = ST_OK;
    r = '0;
    done = 1'b1;
    if (act == ACT_PUSH) begin
      if (model_count >= STACK_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        model_stack[model_count] = val;
        model_count++;
      end
    end else if (act == ACT_ADD || act == ACT_SUB || act == ACT_DIV || act == ACT_MUL) begin
      if (model_count < 2) begin
        res.status = ST_SHORT;
      end else begin
        opb = model_stack[model_count - 1];
        opa = model_stack[model_count - 2];
        case (act)
          ACT_ADD: r = opa + opb;
          ACT_SUB: r = opa - opb;
          ACT_DIV: begin
            if (opb == '0) begin
              res.status = ST_DIV0;
              done = 1'b0;
            end else begin
              ma = opa[DATA_W-1] ? -opa : opa;
              mb = opb[DATA_W-1] ? -opb : opb;
              r = ma / mb;
              if (opa[DATA_W-1] ^ opb[DATA_W-1]) r = -r;
            end
          end
          default: r = opa * opb;
        endcase
        if (done) begin
          model_count--;
          model_stack[model_count - 1] = r;
        end
      end
    end
    res.top = (model_count > 0) ? model_stack[model_count - 1] : '0;
    res.depth = DEPTH_OUT_W'(model_count);
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MINUS_ONE;
      2: return INT_MIN;
      3: return INT_MAX;
      4: return 32'd1;
      5, 6: return 32'($urandom_range(0, 32)) - 32'd16;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
    alu_item_t it;
    it.action = act;
    it.value = val;
    it.gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    it.drain = ($urandom_range(0, 199) == 0);
    pending_items.push_back(it);
  endtask

  task automatic add_random_op();
    add_item(ACT_ADD + 3'($urandom_range(0, 3)), $urandom);
  endtask

  task automatic add_random_idle();
    case ($urandom_range(0, 2))
      0: add_item(ACT_NOP, $urandom);
      1: add_item(ACT_RSVD6, $urandom);
      default: add_item(ACT_RSVD7, $urandom);
    endcase
  endtask

  always @(posedge clk) begin
    alu_item_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) expected_results.push_back(apply_action(in_action, in_push_value));
      if (hold_cnt > 0) begin
        hold_cnt--;
        start <= 1'b0;
      end else if (pending_items.size() == 0) begin
        start <= 1'b0;
        stim_done = 1'b1;
      end else if (pending_items[0].gap > 0) begin
        hold_cnt = pending_items[0].gap - 1;
        pending_items[0].gap = 0;
        start <= 1'b0;
      end else if (pending_items[0].drain && expected_results.size() != 0) begin
        start <= 1'b0;
      end else begin
        nxt = pending_items.pop_front();
        start <= 1'b1;
        in_action <= nxt.action;
        in_push_value <= nxt.value;
      end
    end
  end

  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d top %h depth %0d",
                   out_status, out_top_value, out_stack_depth);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status || out_top_value !== want.top ||
            out_stack_depth !== want.depth) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: status %0d/%0d top %h/%h depth %0d/%0d (expected/actual)",
                     want.status, out_status, want.top, out_top_value,
                     want.depth, out_stack_depth);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int made;
    int seg_len;
    int push_pct;
    int roll;
    made = 0;

    add_item(ACT_NOP, '0);
    add_item(ACT_ADD, INT_MAX);
    add_item(ACT_PUSH, 32'd5);
    add_item(ACT_SUB, '0);
    add_item(ACT_RSVD6, MINUS_ONE);
    add_item(ACT_RSVD7, INT_MIN);
    add_item(ACT_PUSH, INT_MAX);
    add_item(ACT_PUSH, 32'd1);
    add_item(ACT_ADD, '0);
    add_item(ACT_PUSH, INT_MIN);
    pending_items[$].drain = 1'b1;
    add_item(ACT_PUSH, MINUS_ONE);
    add_item(ACT_DIV, '0);
    add_item(ACT_PUSH, '0);
    add_item(ACT_DIV, '0);
    add_item(ACT_MUL, '0);
    add_item(ACT_SUB, '0);
    add_item(ACT_PUSH, -32'sd7);
    add_item(ACT_PUSH, 32'd2);
    add_item(ACT_DIV, '0);
    add_item(ACT_PUSH, -32'sd2);
    add_item(ACT_DIV, '0);
    add_item(ACT_PUSH, INT_MAX);
    add_item(ACT_PUSH, INT_MAX);
    add_item(ACT_MUL, '0);
    add_item(ACT_NOP, MINUS_ONE);

    repeat (STACK_DEPTH + 3) add_item(ACT_PUSH, rand_value());
    repeat (STACK_DEPTH + 2) add_random_op();
    pending_items[$].drain = 1'b1;

    while (made < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 75;
        1: push_pct = 30;
        default: push_pct = 52;
      endcase
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          add_random_idle();
        end else if (roll < 6) begin
          add_item(ACT_PUSH, INT_MIN);
          add_item(ACT_PUSH, MINUS_ONE);
          add_item(ACT_DIV, $urandom);
          made += 2;
        end else if (roll < 8) begin
          add_item(ACT_PUSH, '0);
          add_item(ACT_DIV, $urandom);
          add_item(ACT_ADD, $urandom);
          made += 2;
        end else if (roll < 8 + push_pct) begin
          add_item(ACT_PUSH, rand_value());
        end else begin
          add_random_op();
        end
        made++;
      end
    end

    for (int i = pending_items.size() - QUIET_TAIL; i < pending_items.size(); i++) begin
      pending_items[i].gap = 0;
      pending_items[i].drain = 1'b0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (!stim_done) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- stack_machine_alu.f -----
rtl/sma_pkg.sv
rtl/sma_ram.sv
rtl/sma_ctrl.sv
rtl/sma_dp.sv
rtl/stack_machine_alu.sv
tb/sv/tb_stack_machine_alu.sv
